### sv/lcdw_pkg.sv
// Shared types, command codes and panel constants for the LCD window fill generator.
package lcdw_pkg;

  typedef enum logic [1:0] {
    CMD_ROTATE = 2'd0,
    CMD_PIXEL  = 2'd1,
    CMD_FILL   = 2'd2
  } lcdw_cmd_t;

  localparam logic [7:0] OP_CASET  = 8'h2A;
  localparam logic [7:0] OP_RASET  = 8'h2B;
  localparam logic [7:0] OP_RAMWR  = 8'h2C;
  localparam logic [7:0] OP_MADCTL = 8'h36;

  localparam logic [7:0] MAD_MY  = 8'h80;
  localparam logic [7:0] MAD_MX  = 8'h40;
  localparam logic [7:0] MAD_MV  = 8'h20;
  localparam logic [7:0] MAD_RGB = 8'h08;

  localparam logic [7:0]  OFFSET_RESET = 8'd24;
  localparam logic [13:0] REPEAT_MAX   = 14'd16383;

  localparam int QDEPTH = 4;

  // Last step index of each job kind in the back end
  localparam logic [2:0] STEP_ROT_LAST = 3'd1;
  localparam logic [2:0] STEP_WIN_LAST = 3'd7;

  // Step codes of a window job
  localparam logic [2:0] STEP_CASET = 3'd0;
  localparam logic [2:0] STEP_COL0  = 3'd1;
  localparam logic [2:0] STEP_COL1  = 3'd2;
  localparam logic [2:0] STEP_RASET = 3'd3;
  localparam logic [2:0] STEP_ROW0  = 3'd4;
  localparam logic [2:0] STEP_ROW1  = 3'd5;
  localparam logic [2:0] STEP_RAMWR = 3'd6;
  localparam logic [2:0] STEP_COLOR = 3'd7;

  // Job held between the front end stages, before the repeat count is known
  typedef struct packed {
    logic        is_rot;
    logic [8:0]  col0;
    logic [8:0]  col1;
    logic [8:0]  row0;
    logic [8:0]  row1;
    logic [15:0] color;
    logic [7:0]  span_w;
    logic [7:0]  span_h;
  } lcdw_stage_t;

  // Job queued for the back end
  typedef struct packed {
    logic        is_rot;
    logic [8:0]  col0;
    logic [8:0]  col1;
    logic [8:0]  row0;
    logic [8:0]  row1;
    logic [15:0] color;
    logic [13:0] rep;
  } lcdw_job_t;

  // One result word on the panel link
  typedef struct packed {
    logic        is_command;
    logic        is_halfword;
    logic [15:0] value;
    logic [13:0] repeat_count;
    logic        last;
  } lcdw_word_t;

  function automatic logic [7:0] orient_byte(input logic [1:0] turn);
    logic [7:0] b;
    case (turn)
      2'd0:    b = MAD_RGB | MAD_MX | MAD_MY;
      2'd1:    b = MAD_RGB | MAD_MY | MAD_MV;
      2'd2:    b = MAD_RGB;
      default: b = MAD_RGB | MAD_MX | MAD_MV;
    endcase
    return b;
  endfunction

endpackage

### sv/lcdw_front.sv
// Front end: accepts requests, tracks orientation, clips and builds queued jobs.
module lcdw_front #(
  parameter int PANEL_WIDTH  = 80,
  parameter int PANEL_HEIGHT = 160
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [7:0]         x,
  input  logic [7:0]         y,
  input  logic [7:0]         rect_width,
  input  logic [7:0]         rect_height,
  input  logic [15:0]        pixel_color,
  input  logic [1:0]         turn_request,
  output logic               push,
  output lcdw_pkg::lcdw_job_t push_job,
  input  logic               q_ready
);
  import lcdw_pkg::*;

  localparam logic [7:0] PW = 8'(PANEL_WIDTH);
  localparam logic [7:0] PH = 8'(PANEL_HEIGHT);

  logic [7:0]  panel_offset;
  logic [1:0]  quarter_turn;

  logic        v1;
  logic [1:0]  cmd1;
  logic [7:0]  x1r, y1r, w1r, h1r;
  logic [15:0] color1;
  logic [1:0]  turn1;

  logic        v2;
  lcdw_stage_t st2;

  logic        move1, load2_ok;
  logic        emit1;
  lcdw_stage_t st1_next;

  logic [7:0]  wd, ht, co, ro;
  logic        oob;
  logic [8:0]  xend, yend;
  logic [7:0]  wclip, hclip, xe, ye;
  logic [15:0] product;

  always_comb begin
    wd = quarter_turn[0] ? PH : PW;
    ht = quarter_turn[0] ? PW : PH;
    co = quarter_turn[0] ? 8'd0 : panel_offset;
    ro = quarter_turn[0] ? panel_offset : 8'd0;
    oob = (x1r >= wd) || (y1r >= ht);
    xend = {1'b0, x1r} + {1'b0, w1r} - 9'd1;
    yend = {1'b0, y1r} + {1'b0, h1r} - 9'd1;
    wclip = (xend >= {1'b0, wd}) ? (wd - x1r) : w1r;
    hclip = (yend >= {1'b0, ht}) ? (ht - y1r) : h1r;

    unique case (cmd1)
      CMD_ROTATE: emit1 = 1'b1;
      CMD_PIXEL:  emit1 = !oob;
      CMD_FILL:   emit1 = !oob && (w1r != 8'd0) && (h1r != 8'd0);
      default:    emit1 = 1'b0;
    endcase

    if (cmd1 == CMD_FILL) begin
      xe = x1r + wclip - 8'd1;
      ye = y1r + hclip - 8'd1;
      st1_next.span_w = wclip;
      st1_next.span_h = hclip;
    end else begin
      xe = x1r + 8'd1;
      ye = y1r + 8'd1;
      st1_next.span_w = 8'd1;
      st1_next.span_h = 8'd1;
    end
    st1_next.is_rot = (cmd1 == CMD_ROTATE);
    st1_next.col0   = {1'b0, x1r} + {1'b0, co};
    st1_next.col1   = {1'b0, xe} + {1'b0, co};
    st1_next.row0   = {1'b0, y1r} + {1'b0, ro};
    st1_next.row1   = {1'b0, ye} + {1'b0, ro};
    st1_next.color  = (cmd1 == CMD_ROTATE) ? {8'd0, orient_byte(turn1)} : color1;
  end

  // Stage handshakes: hold a stage while the one after it is full and cannot move on
  assign push     = v2;
  assign load2_ok = !v2 || q_ready;
  assign move1    = v1 && load2_ok;
  assign in_ready = !v1 || move1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_offset <= OFFSET_RESET;
    end else if (cfg_valid) begin
      panel_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      quarter_turn <= 2'd0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (load2_ok) v2 <= move1 && emit1;
      if (move1 && cmd1 == CMD_ROTATE) quarter_turn <= turn1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd1   <= command;
      x1r    <= x;
      y1r    <= y;
      w1r    <= rect_width;
      h1r    <= rect_height;
      color1 <= pixel_color;
      turn1  <= turn_request;
    end
    if (move1) st2 <= st1_next;
  end

  // Saturate the pixel count of the fill
  always_comb begin
    product         = {8'd0, st2.span_w} * {8'd0, st2.span_h};
    push_job.is_rot = st2.is_rot;
    push_job.col0   = st2.col0;
    push_job.col1   = st2.col1;
    push_job.row0   = st2.row0;
    push_job.row1   = st2.row1;
    push_job.color  = st2.color;
    push_job.rep    = (product > {2'b00, REPEAT_MAX}) ? REPEAT_MAX : product[13:0];
  end

endmodule

### sv/lcdw_queue.sv
// Short job queue between front and back end.
module lcdw_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcdw_pkg::lcdw_job_t push_job,
  output logic                q_ready,
  output logic                head_valid,
  output lcdw_pkg::lcdw_job_t head_job,
  input  logic                pop
);
  import lcdw_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  lcdw_job_t       mem [QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;
  logic            do_push, do_pop;

  assign q_ready    = (count != (PW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && q_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

endmodule

### sv/lcdw_back.sv
// Back end: steps through each queued job and drives the registered result word.
module lcdw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  lcdw_pkg::lcdw_job_t  head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lcdw_pkg::lcdw_word_t out_word
);
  import lcdw_pkg::*;

  logic [2:0]  step;
  logic        load, last_step;
  lcdw_word_t  word_next;

  assign load      = head_valid && (!out_valid || out_ready);
  assign last_step = head_job.is_rot ? (step == STEP_ROT_LAST) : (step == STEP_WIN_LAST);
  assign pop       = load && last_step;

  always_comb begin
    word_next.is_command   = 1'b0;
    word_next.is_halfword  = 1'b1;
    word_next.value        = 16'd0;
    word_next.repeat_count = 14'd1;
    word_next.last         = last_step;
    if (head_job.is_rot) begin
      if (step == 3'd0) begin
        word_next.is_command  = 1'b1;
        word_next.is_halfword = 1'b0;
        word_next.value       = {8'd0, OP_MADCTL};
      end else begin
        word_next.is_halfword = 1'b0;
        word_next.value       = head_job.color;
      end
    end else begin
      unique case (step)
        STEP_CASET: begin
          word_next.is_command  = 1'b1;
          word_next.is_halfword = 1'b0;
          word_next.value       = {8'd0, OP_CASET};
        end
        STEP_COL0: word_next.value = {7'd0, head_job.col0};
        STEP_COL1: word_next.value = {7'd0, head_job.col1};
        STEP_RASET: begin
          word_next.is_command  = 1'b1;
          word_next.is_halfword = 1'b0;
          word_next.value       = {8'd0, OP_RASET};
        end
        STEP_ROW0: word_next.value = {7'd0, head_job.row0};
        STEP_ROW1: word_next.value = {7'd0, head_job.row1};
        STEP_RAMWR: begin
          word_next.is_command  = 1'b1;
          word_next.is_halfword = 1'b0;
          word_next.value       = {8'd0, OP_RAMWR};
        end
        STEP_COLOR: begin
          word_next.value        = head_job.color;
          word_next.repeat_count = head_job.rep;
        end
        default: word_next.value = 16'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 3'd0;
    end else begin
      if (!out_valid || out_ready) out_valid <= head_valid;
      if (load) step <= last_step ? 3'd0 : step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_word <= word_next;
  end

endmodule

### sv/lcd_window_fill_command_generator_top.sv
// Top level of the LCD address window and fill command generator.
//
// Drawing requests enter on the in channel (valid/ready) and become the
// command and data words for an SPI panel link on the out channel, one word
// per item, each with a repeat count and a last mark on the final word of a
// request. panel_offset is written on the cfg channel, which is always ready.
//
// A front end registers each request, classifies it against the current
// orientation, clips fills and drops requests that emit nothing. A second
// front stage forms the fill repeat count (one 8x8 multiply, saturated).
// Jobs then wait in a four-entry queue; the back end steps through each job,
// one result word per cycle while out_ready holds, into an output register.
//
// A request passes the input register, the second front stage, the queue and
// the output register. A pixel or fill emits CASET, RASET and RAMWR with data,
// a rotation MADCTL and its byte; a request that emits nothing never
// reaches the queue. Requests are accepted every cycle while the queue has
// room. When the receiver stalls, the output word holds and the queue fills,
// then the front stalls in turn. Reset empties the pipeline and queue, sets
// the quarter turn to zero and panel_offset to 24, and emits nothing.
module lcd_window_fill_command_generator_top #(
  parameter int PANEL_WIDTH  = 80,
  parameter int PANEL_HEIGHT = 160
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  x,
  input  logic [7:0]  y,
  input  logic [7:0]  rect_width,
  input  logic [7:0]  rect_height,
  input  logic [15:0] pixel_color,
  input  logic [1:0]  turn_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_command,
  output logic        is_halfword,
  output logic [15:0] value,
  output logic [13:0] repeat_count,
  output logic        last
);
  import lcdw_pkg::*;

  logic       push, q_ready, head_valid, pop;
  lcdw_job_t  push_job, head_job;
  lcdw_word_t out_word;

  // Configuration writes land at once
  assign cfg_ready = 1'b1;

  lcdw_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .x            (x),
    .y            (y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .pixel_color  (pixel_color),
    .turn_request (turn_request),
    .push         (push),
    .push_job     (push_job),
    .q_ready      (q_ready)
  );

  lcdw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .q_ready    (q_ready),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  lcdw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  // Split the result word onto its ports
  assign is_command   = out_word.is_command;
  assign is_halfword  = out_word.is_halfword;
  assign value        = out_word.value;
  assign repeat_count = out_word.repeat_count;
  assign last         = out_word.last;

endmodule
